// ===== design/btt_pkg.sv =====
// Shared types, constants and the slot hash for the bound transposition table.
// No dependencies; imported by every module of the block.
`default_nettype none

package btt_pkg;

    // Default table size, as log2 of the slot count
    localparam int BTT_INDEX_BITS = 16;

    localparam int KEY_W   = 63;
    localparam int TAG_W   = 64;
    localparam int SCORE_W = 8;

    // Operation codes carried in the input tuser
    localparam logic [1:0] FUNC_PROBE = 2'd0;
    localparam logic [1:0] FUNC_LOWER = 2'd1;
    localparam logic [1:0] FUNC_UPPER = 2'd2;

    // Bound values reported when a bound is not known
    localparam logic signed [SCORE_W-1:0] UNSET_LOWER = -8'sd127;
    localparam logic signed [SCORE_W-1:0] UNSET_UPPER = 8'sd127;

    // Flag bit positions within an entry
    localparam int FLAG_LOWER = 0;
    localparam int FLAG_UPPER = 1;

    // One table slot: owner tag (zero = empty), both bounds and their flags
    typedef struct packed {
        logic [TAG_W-1:0]          tag;
        logic signed [SCORE_W-1:0] lower;
        logic signed [SCORE_W-1:0] upper;
        logic [1:0]                flags;
    } entry_t;

    // One result item
    typedef struct packed {
        logic                      hit;
        logic signed [SCORE_W-1:0] lower_bound;
        logic signed [SCORE_W-1:0] upper_bound;
        logic                      evicted;
        logic                      updated;
    } result_t;

    // Write-back request toward the slot memory
    typedef struct packed {
        logic   en;
        entry_t data;
    } wr_req_t;

    // Fold the key onto itself; the caller keeps the low index bits
    function automatic logic [TAG_W-1:0] btt_fold(input logic [KEY_W-1:0] key);
        logic [TAG_W-1:0] h;
        h = {1'b0, key} ^ ({1'b0, key} >> 23);
        h = h ^ (h >> 41);
        return h;
    endfunction

endpackage

`default_nettype wire

// ===== design/btt_slot_mem.sv =====
// Slot memory of the bound transposition table: one write port, one read
// port with registered read data. Uses btt_pkg for the entry type.
`default_nettype none

module btt_slot_mem
    import btt_pkg::*;
#(
    parameter int INDEX_BITS = BTT_INDEX_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rd_en,
    input  wire logic [INDEX_BITS-1:0] rd_addr,
    output entry_t                     rd_data,
    input  wire logic                  wr_en,
    input  wire logic [INDEX_BITS-1:0] wr_addr,
    input  entry_t                     wr_data
);

    localparam int SLOTS = 1 << INDEX_BITS;

    entry_t mem [0:SLOTS-1];
    entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/btt_update.sv =====
// Modify stage of the read-modify-write: decides hit, eviction and bound
// tightening from the slot read back. Uses btt_pkg types and constants.
`default_nettype none

module btt_update
    import btt_pkg::*;
(
    input  wire logic [1:0]                func,
    input  wire logic [KEY_W-1:0]          key,
    input  wire logic signed [SCORE_W-1:0] score,
    input  entry_t                         held,
    output wr_req_t                        wr_req,
    output result_t                        result
);

    logic [TAG_W-1:0] tag;
    logic             match;
    logic [1:0]       base_flags;
    logic             tighten_lower;
    logic             tighten_upper;

    assign tag   = {1'b0, key} + {{(TAG_W-1){1'b0}}, 1'b1};
    assign match = (held.tag == tag);

    // A store to a slot owned by another tag starts with no bounds set
    assign base_flags = match ? held.flags : 2'b00;

    assign tighten_lower = !(base_flags[FLAG_LOWER] && (score <= held.lower));
    assign tighten_upper = !(base_flags[FLAG_UPPER] && (score >= held.upper));

    always_comb
    begin
        result.hit         = 1'b0;
        result.lower_bound = UNSET_LOWER;
        result.upper_bound = UNSET_UPPER;
        result.evicted     = 1'b0;
        result.updated     = 1'b0;

        wr_req.en          = 1'b0;
        wr_req.data.tag    = tag;
        wr_req.data.lower  = held.lower;
        wr_req.data.upper  = held.upper;
        wr_req.data.flags  = base_flags;

        case (func)
            FUNC_PROBE:
            begin
                // On a hit report each stored bound whose flag is set, unset values otherwise
                if (match)
                begin
                    result.hit = 1'b1;
                    if (held.flags[FLAG_LOWER])
                    begin
                        result.lower_bound = held.lower;
                    end
                    if (held.flags[FLAG_UPPER])
                    begin
                        result.upper_bound = held.upper;
                    end
                end
            end
            FUNC_LOWER:
            begin
                wr_req.en      = 1'b1;
                result.evicted = (held.tag != '0) && !match;
                if (tighten_lower)
                begin
                    wr_req.data.lower             = score;
                    wr_req.data.flags[FLAG_LOWER] = 1'b1;
                    result.updated                = 1'b1;
                end
            end
            FUNC_UPPER:
            begin
                wr_req.en      = 1'b1;
                result.evicted = (held.tag != '0) && !match;
                if (tighten_upper)
                begin
                    wr_req.data.upper             = score;
                    wr_req.data.flags[FLAG_UPPER] = 1'b1;
                    result.updated                = 1'b1;
                end
            end
            default:
            begin
                // Unused operation code: table untouched, answer as a miss
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/bound_transposition_table_unit.sv =====
// Bound transposition table: a direct-mapped table of lower and upper score
// bounds indexed by a folded position key. Each accepted item (probe, raise
// the lower bound, or lower the upper bound) yields exactly one result
// transfer. In the accept cycle the slot is read from the synchronous slot
// memory; in the lookup state that follows, once the output register is free,
// the read data is modified, written back and the result loaded into the
// output register. No new item is accepted until this read-modify-write on the
// single slot memory is done. A new item is accepted while a result still
// waits in the output register. After reset the block sweeps the memory to
// empty, one slot per cycle, and accepts no item until the sweep is done.
// Built from btt_pkg, btt_slot_mem and btt_update.
`default_nettype none

module bound_transposition_table_unit
    import btt_pkg::*;
#(
    parameter int INDEX_BITS = BTT_INDEX_BITS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // key[62:0], score[70:63], zero pad
    input  wire logic [1:0]  s_axis_tuser,  // func[1:0]

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata   // hit, lower_bound, upper_bound,
                                            // evicted, updated, zero pad
);

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_LOOKUP = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [INDEX_BITS-1:0]   clr_addr_reg, clr_addr_next;
    logic [INDEX_BITS-1:0]   index_reg;
    logic [1:0]              func_reg;
    logic [KEY_W-1:0]        key_reg;
    logic signed [SCORE_W-1:0] score_reg;

    logic                    out_valid_reg, out_valid_next;
    result_t                 out_reg;

    logic                    accept;
    logic                    out_free;
    logic                    finish;
    logic [INDEX_BITS-1:0]   in_index;
    logic [TAG_W-1:0]        in_fold;

    entry_t                  rd_data;
    wr_req_t                 upd_req;
    result_t                 upd_result;

    logic                    mem_wr_en;
    logic [INDEX_BITS-1:0]   mem_wr_addr;
    entry_t                  mem_wr_data;

    // Slot index of the incoming key
    assign in_fold  = btt_fold(s_axis_tdata[KEY_W-1:0]);
    assign in_index = in_fold[INDEX_BITS-1:0];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign finish        = (state_reg == ST_LOOKUP) && out_free;

    btt_slot_mem #(
        .INDEX_BITS (INDEX_BITS)
    ) u_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (in_index),
        .rd_data (rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    btt_update u_update (
        .func   (func_reg),
        .key    (key_reg),
        .score  (score_reg),
        .held   (rd_data),
        .wr_req (upd_req),
        .result (upd_result)
    );

    // Write port: clearing sweep, else write-back of the modified slot
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_reg;
            mem_wr_data = '0;
        end
        else
        begin
            mem_wr_en   = finish && upd_req.en;
            mem_wr_addr = index_reg;
            mem_wr_data = upd_req.data;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + {{(INDEX_BITS-1){1'b0}}, 1'b1};
                if (clr_addr_reg == {INDEX_BITS{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Output valid: set on finish, drop once the transfer completes
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the accepted item for the modify cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            index_reg <= in_index;
            func_reg  <= s_axis_tuser;
            key_reg   <= s_axis_tdata[KEY_W-1:0];
            score_reg <= s_axis_tdata[KEY_W+SCORE_W-1:KEY_W];
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_reg <= upd_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0,
                            out_reg.updated,
                            out_reg.evicted,
                            out_reg.upper_bound,
                            out_reg.lower_bound,
                            out_reg.hit};

endmodule

`default_nettype wire
